[rtl/core/iirdf1_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Types, constants and helpers for the direct form I IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

    // store depth and field widths
    localparam int TAPS      = 16;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int COUNT_W   = 5;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;

    // digit-serial multiplier: sample digits of DIGIT_W bits, lowest first
    localparam int DIGIT_LOG = 2;
    localparam int DIGIT_W   = 1 << DIGIT_LOG;
    localparam int DIGITS    = SAMPLE_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);
    localparam int PART_W    = COEF_W + DIGIT_W + 1;

    // Q5.35 products, up to 2*TAPS-1 of them summed
    localparam int ACC_W     = SAMPLE_W + COEF_W + $clog2(2 * TAPS) + 1;
    localparam int FRAC_DROP = 20;
    localparam int Y_W       = ACC_W - FRAC_DROP;

    // configuration port
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_COUNT = 2'd0,
        CFG_FB_COUNT = 2'd1,
        CFG_SPARE_2  = 2'd2,
        CFG_SPARE_3  = 2'd3
    } cfg_idx_t;

    // item commands
    typedef enum logic [1:0] {
        CMD_FILTER  = 2'd0,
        CMD_LOAD_FF = 2'd1,
        CMD_LOAD_FB = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND
    } iir_st_t;

    // controls from the state decode to the datapath
    typedef struct packed {
        logic in_ready;
        logic mac_en;
        logic round_load;
    } iir_ctrl_t;

    // last tap index in use for a tap count, count clamped to 1..TAPS
    function automatic logic [TAP_W-1:0] count_last(input logic [COUNT_W-1:0] count);
        logic [TAP_W-1:0] last;
        if (count == '0)
            last = '0;
        else if (count > COUNT_W'(TAPS))
            last = TAP_W'(TAPS - 1);
        else
            last = TAP_W'(count - 1'b1);
        return last;
    endfunction

endpackage

`default_nettype wire

[rtl/core/iir_direct_form_one_filter.sv]
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter with a digit-serial multiply-accumulate.
// Operation: a filter item is summed over the feedforward taps, then the
//   feedback taps (NB, NA the clamped tap counts), one sample digit of 4 bits
//   per cycle through the shared coefficient-by-digit unit, then rounded.
// Flow: a new filter item is taken only after the last result is loaded
//   into the output register; load and clear items leave the block idle.
// Reset: coefficients and histories cleared at once, tap counts set to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [iirdf1_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [iirdf1_pkg::COUNT_W-1:0]        cfg_data,
    // input items
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            command,
    input  wire logic [iirdf1_pkg::TAP_W-1:0]          coef_index,
    input  wire logic signed [iirdf1_pkg::COEF_W-1:0]  coef_value,
    input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_in,
    // result items
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0]     sample_out,
    output logic                                       saturated
);

    localparam int TAPS     = iirdf1_pkg::TAPS;
    localparam int TAP_W    = iirdf1_pkg::TAP_W;
    localparam int SAMPLE_W = iirdf1_pkg::SAMPLE_W;
    localparam int COEF_W   = iirdf1_pkg::COEF_W;
    localparam int DIGIT_W  = iirdf1_pkg::DIGIT_W;
    localparam int DIG_W    = iirdf1_pkg::DIG_CNT_W;
    localparam int PART_W   = iirdf1_pkg::PART_W;
    localparam int ACC_W    = iirdf1_pkg::ACC_W;
    localparam int Y_W      = iirdf1_pkg::Y_W;
    localparam int DROP     = iirdf1_pkg::FRAC_DROP;

    iirdf1_pkg::iir_st_t   state_reg, state_next;
    iirdf1_pkg::iir_ctrl_t ctrl;

    logic [iirdf1_pkg::COUNT_W-1:0] ff_count_reg, fb_count_reg;
    logic signed [COEF_W-1:0]   ff_coef_reg [TAPS];
    logic signed [COEF_W-1:0]   fb_coef_reg [TAPS];
    logic signed [SAMPLE_W-1:0] in_hist_reg [TAPS];
    logic signed [SAMPLE_W-1:0] out_hist_reg [TAPS];

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [TAP_W-1:0]           tap_reg;
    logic [DIG_W-1:0]           dig_reg;
    logic                       fb_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       sat_reg;

    logic [TAP_W-1:0]           nb_last, na_last;
    logic                       in_xfer, filter_xfer, last_step;
    logic signed [SAMPLE_W-1:0] op_sample;
    logic signed [COEF_W-1:0]   op_coef;
    logic [DIGIT_W-1:0]         digit_raw;
    logic signed [DIGIT_W:0]    digit_s;
    logic signed [PART_W-1:0]   partial;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [Y_W-1:0]      y_full;
    logic                       pos_ovf, neg_ovf;
    logic signed [SAMPLE_W-1:0] y_sat;

    // handshake decode
    assign cfg_ready   = 1'b1;
    assign in_ready    = ctrl.in_ready;
    assign in_xfer     = in_valid && ctrl.in_ready;
    assign filter_xfer = in_xfer && (command == iirdf1_pkg::CMD_FILTER);
    assign nb_last     = iirdf1_pkg::count_last(ff_count_reg);
    assign na_last     = iirdf1_pkg::count_last(fb_count_reg);

    // final digit of the final tap
    assign last_step = (dig_reg == DIG_W'(iirdf1_pkg::DIGITS - 1)) &&
                       ((fb_reg && tap_reg == na_last) ||
                        (!fb_reg && tap_reg == nb_last && na_last == '0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iirdf1_pkg::ST_IDLE:
            begin
                if (filter_xfer)
                    state_next = iirdf1_pkg::ST_MAC;
            end
            iirdf1_pkg::ST_MAC:
            begin
                if (last_step)
                    state_next = iirdf1_pkg::ST_ROUND;
            end
            iirdf1_pkg::ST_ROUND:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = iirdf1_pkg::ST_IDLE;
            end
            default:
                state_next = iirdf1_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            iirdf1_pkg::ST_IDLE:  ctrl.in_ready   = 1'b1;
            iirdf1_pkg::ST_MAC:   ctrl.mac_en     = 1'b1;
            iirdf1_pkg::ST_ROUND: ctrl.round_load = !out_valid_reg || out_ready;
            default:              ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iirdf1_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_count_reg <= iirdf1_pkg::COUNT_W'(1);
            fb_count_reg <= iirdf1_pkg::COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (iirdf1_pkg::cfg_idx_t'(cfg_index))
                iirdf1_pkg::CFG_FF_COUNT: ff_count_reg <= cfg_data;
                iirdf1_pkg::CFG_FB_COUNT: fb_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient stores, written by load transfers
    // a 4-bit index always lies inside the 16-entry store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                ff_coef_reg[i] <= '0;
                fb_coef_reg[i] <= '0;
            end
        end
        else if (in_xfer)
        begin
            if (command == iirdf1_pkg::CMD_LOAD_FF)
                ff_coef_reg[coef_index] <= coef_value;
            else if (command == iirdf1_pkg::CMD_LOAD_FB)
                fb_coef_reg[coef_index] <= coef_value;
        end
    end

    // sample histories: shift on each result, cleared by a clear transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (in_xfer && command == iirdf1_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else if (ctrl.round_load)
        begin
            for (int i = TAPS - 1; i > 0; i--)
            begin
                in_hist_reg[i]  <= in_hist_reg[i-1];
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
            in_hist_reg[0]  <= x_reg;
            out_hist_reg[0] <= y_sat;
        end
    end

    // operand selection for the current tap
    always_comb
    begin
        if (fb_reg)
        begin
            op_sample = out_hist_reg[tap_reg - 1'b1];
            op_coef   = fb_coef_reg[tap_reg];
        end
        else
        begin
            op_sample = (tap_reg == '0) ? x_reg : in_hist_reg[tap_reg - 1'b1];
            op_coef   = ff_coef_reg[tap_reg];
        end
    end

    // coefficient times one sample digit; the top digit carries the sign
    assign digit_raw = op_sample[dig_reg*DIGIT_W +: DIGIT_W];
    assign digit_s   = (dig_reg == DIG_W'(iirdf1_pkg::DIGITS - 1))
                       ? $signed({digit_raw[DIGIT_W-1], digit_raw})
                       : $signed({1'b0, digit_raw});
    assign partial   = op_coef * digit_s;
    assign term      = ACC_W'(partial) <<< {dig_reg, {iirdf1_pkg::DIGIT_LOG{1'b0}}};
    assign acc_next  = fb_reg ? acc_reg - term : acc_reg + term;

    // multiply-accumulate sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            dig_reg <= '0;
            fb_reg  <= 1'b0;
        end
        else if (filter_xfer)
        begin
            tap_reg <= '0;
            dig_reg <= '0;
            fb_reg  <= 1'b0;
        end
        else if (ctrl.mac_en)
        begin
            dig_reg <= dig_reg + 1'b1;
            if (dig_reg == DIG_W'(iirdf1_pkg::DIGITS - 1))
            begin
                if (!fb_reg && tap_reg == nb_last)
                begin
                    fb_reg  <= 1'b1;
                    tap_reg <= TAP_W'(1);
                end
                else
                    tap_reg <= tap_reg + 1'b1;
            end
        end
    end

    // accumulator and latched sample
    always_ff @(posedge clk)
    begin
        if (filter_xfer)
        begin
            x_reg   <= sample_in;
            acc_reg <= '0;
        end
        else if (ctrl.mac_en)
            acc_reg <= acc_next;
    end

    // round half up to Q1.15, then clip
    assign rounded = acc_reg + (ACC_W'(1) <<< (DROP - 1));
    assign y_full  = Y_W'(rounded >>> DROP);
    assign pos_ovf = !y_full[Y_W-1] && (|y_full[Y_W-2:SAMPLE_W-1]);
    assign neg_ovf = y_full[Y_W-1] && !(&y_full[Y_W-2:SAMPLE_W-1]);

    always_comb
    begin
        priority if (pos_ovf)
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (neg_ovf)
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            y_sat = y_full[SAMPLE_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.round_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.round_load)
        begin
            sample_out_reg <= y_sat;
            sat_reg        <= pos_ovf || neg_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = sat_reg;

    // feedback taps stay within the active range, never tap zero
    a_fb_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iirdf1_pkg::ST_MAC && fb_reg) |->
            (tap_reg != '0 && tap_reg <= na_last))
        else $error("feedback tap out of range");

    // feedforward taps stay within the active range
    a_ff_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iirdf1_pkg::ST_MAC && !fb_reg) |-> (tap_reg <= nb_last))
        else $error("feedforward tap out of range");

    // a filter transfer starts the accumulation at the first digit of b0
    a_filter_start: assert property (@(posedge clk) disable iff (!rst_n)
        filter_xfer |=> (state_reg == iirdf1_pkg::ST_MAC && tap_reg == '0 &&
                         dig_reg == '0 && !fb_reg))
        else $error("filter transfer did not start accumulation");

    // a new result only comes from the rounding step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == iirdf1_pkg::ST_ROUND))
        else $error("result raised outside rounding step");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |->
            (sample_out_reg == {1'b0, {(SAMPLE_W-1){1'b1}}} ||
             sample_out_reg == {1'b1, {(SAMPLE_W-1){1'b0}}}))
        else $error("saturation flag without clipped value");

endmodule

`default_nettype wire

[dv/iir_direct_form_one_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_test
// Self-checking bench for the direct form I IIR filter. A scoreboard keeps
// its own coefficient stores, sample histories and tap counts, works out
// each filtered sample with exact 64-bit sums, and compares every output
// transfer in order. Directed items cover saturation, rounding, ignored
// a0 loads and history clears; random phases change the tap counts and mix
// coefficient loads, sample runs and stray commands under random back-pressure.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_test;

    import iirdf1_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int SETTLE_CYCLES = 140;
    localparam int IDLE_LIMIT    = 4000;
    localparam int ITEM_TARGET   = 825;
    localparam int REPORT_MAX    = 50;

    localparam logic signed [COEF_W-1:0] COEF_MAX  = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN  = 24'sh800000;
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 24'sh100000;
    localparam logic signed [COEF_W-1:0] COEF_HALF = 24'sh080000;

    // one filtered sample as the block should return it
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       sat;
    } filtered_t;

    // scoreboard: filter state and the queue of samples still to come out
    class filter_scoreboard;
        logic signed [COEF_W-1:0]   ff_coef [TAPS];
        logic signed [COEF_W-1:0]   fb_coef [TAPS];
        logic signed [SAMPLE_W-1:0] x_hist  [TAPS];
        logic signed [SAMPLE_W-1:0] y_hist  [TAPS];
        logic [COUNT_W-1:0]         ff_count;
        logic [COUNT_W-1:0]         fb_count;
        filtered_t                  pending_samples[$];
        int                         errors;

        function new();
            foreach (ff_coef[i])
            begin
                ff_coef[i] = '0;
                fb_coef[i] = '0;
                x_hist[i]  = '0;
                y_hist[i]  = '0;
            end
            ff_count = COUNT_W'(1);
            fb_count = COUNT_W'(1);
            errors   = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // a count of zero means one tap, anything past the store means all taps
        function int taps_in_use(logic [COUNT_W-1:0] count);
            if (count == '0)
                return 1;
            if (count > COUNT_W'(TAPS))
                return TAPS;
            return int'(count);
        endfunction

        function void write_config(cfg_idx_t idx, logic [COUNT_W-1:0] data);
            case (idx)
                CFG_FF_COUNT: ff_count = data;
                CFG_FB_COUNT: fb_count = data;
                default: ;
            endcase
        endfunction

        // exact Q5.35 sum, round half up to Q1.15, clip, then shift histories
        function filtered_t filter_sample(logic signed [SAMPLE_W-1:0] x);
            longint    acc;
            longint    y;
            int        nb;
            int        na;
            int        i;
            filtered_t r;
            nb  = taps_in_use(ff_count);
            na  = taps_in_use(fb_count);
            acc = longint'(ff_coef[0]) * longint'(x);
            for (i = 1; i < nb; i++)
                acc += longint'(ff_coef[i]) * longint'(x_hist[i-1]);
            for (i = 1; i < na; i++)
                acc -= longint'(fb_coef[i]) * longint'(y_hist[i-1]);
            y = (acc + 64'sd524288) >>> 20;
            r.sat = 1'b0;
            if (y > 64'sd32767)
            begin
                y     = 64'sd32767;
                r.sat = 1'b1;
            end
            if (y < -64'sd32768)
            begin
                y     = -64'sd32768;
                r.sat = 1'b1;
            end
            r.value = y[SAMPLE_W-1:0];
            for (i = TAPS - 1; i > 0; i--)
            begin
                x_hist[i] = x_hist[i-1];
                y_hist[i] = y_hist[i-1];
            end
            x_hist[0] = x;
            y_hist[0] = r.value;
            return r;
        endfunction

        function void note_input(cmd_t cmd, logic [TAP_W-1:0] idx,
                                 logic signed [COEF_W-1:0] coef,
                                 logic signed [SAMPLE_W-1:0] x);
            case (cmd)
                CMD_LOAD_FF: ff_coef[idx] = coef;
                CMD_LOAD_FB: fb_coef[idx] = coef;
                CMD_CLEAR:
                begin
                    foreach (x_hist[i])
                    begin
                        x_hist[i] = '0;
                        y_hist[i] = '0;
                    end
                end
                default: pending_samples.push_back(filter_sample(x));
            endcase
        endfunction

        task check_result(logic signed [SAMPLE_W-1:0] value, logic sat);
            filtered_t want;
            if (pending_samples.size() == 0)
            begin
                report($sformatf("output %0d with no sample waiting", value));
                return;
            end
            want = pending_samples.pop_front();
            if (value !== want.value)
                report($sformatf("sample_out %0d, expected %0d", value, want.value));
            if (sat !== want.sat)
                report($sformatf("saturated %b, expected %b (sample %0d)",
                                 sat, want.sat, want.value));
        endtask
    endclass

    // block inputs, all known from time zero
    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [COUNT_W-1:0]          cfg_data   = '0;
    logic                        in_valid   = 1'b0;
    logic [1:0]                  command    = '0;
    logic [TAP_W-1:0]            coef_index = '0;
    logic signed [COEF_W-1:0]    coef_value = '0;
    logic signed [SAMPLE_W-1:0]  sample_in  = '0;
    logic                        out_ready  = 1'b0;

    // block outputs
    logic                        cfg_ready;
    logic                        in_ready;
    logic                        out_valid;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        saturated;

    filter_scoreboard sb;
    int idle_cycles = 0;
    int items_sent  = 0;
    int burst_left  = 1;
    int rx_mode     = 0;
    int mode_left   = 0;

    iir_direct_form_one_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // output back-pressure: free-flowing, coin-toss and mostly-stalled stretches
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   <= $urandom_range(0, 2);
            mode_left <= $urandom_range(64, 256);
        end
        else
            mode_left <= mode_left - 1;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 15) < 3);
        endcase
    end

    // transfer monitor on all three channels, plus the stall counter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_config(cfg_idx_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                sb.note_input(cmd_t'(command), coef_index, coef_value, sample_in);
            if (out_valid && out_ready)
                sb.check_result(sample_out, saturated);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready)
                || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("iir_direct_form_one_filter_test NOT OK");
        $finish;
    end

    // one input item; bursts end in a random gap, which may be empty
    task automatic send_item(cmd_t cmd, logic [TAP_W-1:0] idx,
                             logic signed [COEF_W-1:0] coef,
                             logic signed [SAMPLE_W-1:0] x);
        int gap;
        command    <= cmd;
        coef_index <= idx;
        coef_value <= coef;
        sample_in  <= x;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic feed_sample(logic signed [SAMPLE_W-1:0] x);
        send_item(CMD_FILTER, TAP_W'($urandom), COEF_W'($urandom), x);
    endtask

    task automatic load_coef(cmd_t cmd, logic [TAP_W-1:0] idx,
                             logic signed [COEF_W-1:0] coef);
        send_item(cmd, idx, coef, SAMPLE_W'($urandom));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [COUNT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every sample to come out, then let load and clear items finish
    // one edge first so the monitor has noted the last transfer
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // half of the taps gentle so outputs stay in range, the rest random or at full scale
    function automatic logic signed [COEF_W-1:0] pick_coef();
        int v;
        v = $urandom_range(0, 262143) - 131072;
        case ($urandom_range(0, 7))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2, 3:    return COEF_W'($urandom);
            default: return COEF_W'(v);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return COUNT_W'(0);
            1:       return COUNT_W'(1);
            2:       return COUNT_W'(TAPS);
            3:       return COUNT_W'(31);
            4:       return COUNT_W'(TAPS + 1);
            default: return COUNT_W'($urandom_range(0, 31));
        endcase
    endfunction

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation both ways, rounding of half, ignored a0
        feed_sample(16'sh7FFF);
        load_coef(CMD_LOAD_FF, 0, COEF_MAX);
        feed_sample(16'sh7FFF);
        feed_sample(16'sh8000);
        load_coef(CMD_LOAD_FF, 0, COEF_MIN);
        feed_sample(16'sh8000);
        load_coef(CMD_LOAD_FF, 0, COEF_HALF);
        feed_sample(16'sh0001);
        feed_sample(-16'sh0001);
        load_coef(CMD_LOAD_FB, 0, COEF_MAX);
        load_coef(CMD_LOAD_FF, 0, COEF_ONE);
        feed_sample(16'sh8000);
        feed_sample(16'sh7FFF);

        // counts past the store, zero counts and spare registers
        settle();
        write_reg(CFG_FF_COUNT, COUNT_W'(31));
        write_reg(CFG_FB_COUNT, COUNT_W'(0));
        write_reg(CFG_SPARE_2, COUNT_W'(31));
        write_reg(CFG_SPARE_3, COUNT_W'(0));
        load_coef(CMD_LOAD_FF, 15, COEF_ONE);
        load_coef(CMD_LOAD_FB, 15, COEF_MIN);
        feed_sample(16'sh7FFF);
        send_item(CMD_CLEAR, TAP_W'($urandom), COEF_W'($urandom), SAMPLE_W'($urandom));
        feed_sample(16'sh8000);

        // feedback path at full length, then a fresh signal
        settle();
        write_reg(CFG_FF_COUNT, COUNT_W'(0));
        write_reg(CFG_FB_COUNT, COUNT_W'(31));
        load_coef(CMD_LOAD_FB, 1, COEF_HALF);
        feed_sample(16'sh7FFF);
        feed_sample('0);
        feed_sample('0);
        send_item(CMD_CLEAR, TAP_W'($urandom), COEF_W'($urandom), SAMPLE_W'($urandom));
        feed_sample('0);

        // random phases: new counts, then loads, clears and sample runs
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_FF_COUNT, pick_count());
                write_reg(CFG_FB_COUNT, pick_count());
            end
            else
            begin
                write_reg(CFG_FB_COUNT, pick_count());
                write_reg(CFG_FF_COUNT, pick_count());
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(cfg_idx_t'($urandom_range(2, 3)), COUNT_W'($urandom));
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1))
                    send_item(CMD_CLEAR, TAP_W'($urandom), COEF_W'($urandom),
                              SAMPLE_W'($urandom));
                repeat ($urandom_range(0, 6))
                    load_coef($urandom_range(0, 1) ? CMD_LOAD_FF : CMD_LOAD_FB,
                              TAP_W'($urandom), pick_coef());
                repeat ($urandom_range(4, 24))
                    feed_sample(pick_sample());
                // stray items of any kind
                repeat ($urandom_range(0, 3))
                    send_item(cmd_t'($urandom_range(0, 3)), TAP_W'($urandom),
                              pick_coef(), pick_sample());
            end
        end

        settle();
        if (sb.pending_samples.size() != 0)
            sb.report("samples still expected at end of run");
        if (sb.errors == 0)
            $display("iir_direct_form_one_filter_test OK");
        else
            $display("iir_direct_form_one_filter_test NOT OK");
        $finish;
    end

endmodule

[iir_direct_form_one_filter.f]
rtl/core/iirdf1_pkg.sv
rtl/core/iir_direct_form_one_filter.sv
dv/iir_direct_form_one_filter_test.sv
